FILE: design/psf_pkg.sv
// Shared constants and control types for the per-sender sequence filter.
`timescale 1ns / 1ps
`default_nettype none
package psf_pkg;

	// Default number of teammate slots.
	localparam int SLOTS_DEF = 13;

	// Field widths.
	localparam int PLAYER_W = 8;
	localparam int TEAM_W   = 8;
	localparam int SEQ_W    = 32;
	localparam int COST_W   = 24;
	localparam int TIME_W   = 32;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 32;

	// Operation codes.
	localparam logic OP_PACKET = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_OWN_PLAYER       = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OWN_TEAM         = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEPTANCE_GAP   = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FRESHNESS_TIMEOUT = 8'd3;

	// Configuration reset values.
	localparam logic [PLAYER_W-1:0] OWN_PLAYER_RST = 8'd1;
	localparam logic [TEAM_W-1:0]   OWN_TEAM_RST   = 8'd0;
	localparam logic [TIME_W-1:0]   GAP_RST        = 32'd2000;
	localparam logic [TIME_W-1:0]   FRESH_RST      = 32'd2000;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;        // capture the incoming word
		logic pkt_rd;      // read the sender's slot
		logic pkt_commit;  // decide and store a packet
		logic walk_rd;     // read the next slot of a query walk
	} psf_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic walk_last;   // the walk is reading the final slot
	} psf_sts_t;

endpackage
`default_nettype wire

FILE: design/psf_ctrl.sv
// Controller state machine for the per-sender sequence filter.
`timescale 1ns / 1ps
`default_nettype none
module psf_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic              op,
	input  wire psf_pkg::psf_sts_t sts,
	output psf_pkg::psf_cmd_t      cmd,
	output logic                   busy,
	output logic                   done
);
	import psf_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PKT_RD,
		ST_PKT_DEC,
		ST_WALK,
		ST_TAIL
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   done_q;

	// Command decode from the current state.
	always_comb begin
		cmd            = '0;
		cmd.load       = (state_q == ST_IDLE) && start;
		cmd.pkt_rd     = (state_q == ST_PKT_RD);
		cmd.pkt_commit = (state_q == ST_PKT_DEC);
		cmd.walk_rd    = (state_q == ST_WALK);
	end

	// State register with registered busy and done strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						busy_q  <= 1'b1;
						state_q <= (op == OP_QUERY) ? ST_WALK : ST_PKT_RD;
					end
				end
				ST_PKT_RD: begin
					state_q <= ST_PKT_DEC;
				end
				ST_PKT_DEC: begin
					busy_q  <= 1'b0;
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_WALK: begin
					if (sts.walk_last) begin
						state_q <= ST_TAIL;
					end
				end
				ST_TAIL: begin
					busy_q  <= 1'b0;
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					busy_q  <= 1'b0;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy = busy_q;
	assign done = done_q;

endmodule
`default_nettype wire

FILE: design/psf_dp.sv
// Datapath of the per-sender sequence filter: registers, slot memory and compares.
`timescale 1ns / 1ps
`default_nettype none
module psf_dp #(
	parameter int SLOTS = psf_pkg::SLOTS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire psf_pkg::psf_cmd_t               cmd,
	output psf_pkg::psf_sts_t                    sts,
	input  wire logic                            op,
	input  wire logic [psf_pkg::PLAYER_W-1:0]    sender_player,
	input  wire logic [psf_pkg::TEAM_W-1:0]      sender_team,
	input  wire logic [psf_pkg::SEQ_W-1:0]       packet_id,
	input  wire logic [psf_pkg::COST_W-1:0]      time_to_ball,
	input  wire logic [psf_pkg::TIME_W-1:0]      current_time,
	input  wire logic                            cfg_we,
	input  wire logic [psf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [psf_pkg::CFG_DATA_W-1:0]  cfg_data,
	output logic                                 accepted,
	output logic                                 closest
);
	import psf_pkg::*;

	localparam int SLOT_W = $clog2(SLOTS);

	// Configuration registers.
	logic [PLAYER_W-1:0] own_player_q;
	logic [TEAM_W-1:0]   own_team_q;
	logic [TIME_W-1:0]   gap_q;
	logic [TIME_W-1:0]   fresh_q;

	// Captured item.
	logic [PLAYER_W-1:0] who_q;
	logic [TEAM_W-1:0]   team_q;
	logic [SEQ_W-1:0]    seq_q;
	logic [COST_W-1:0]   cost_q;
	logic [TIME_W-1:0]   now_q;

	// Slot store.
	logic [SLOTS-1:0]  slot_valid_q;
	logic [SEQ_W-1:0]  seq_mem  [SLOTS];
	logic [TIME_W-1:0] arr_mem  [SLOTS];
	logic [COST_W-1:0] cost_mem [SLOTS];

	// Registered read port.
	logic              vld_rd_s1;
	logic [SEQ_W-1:0]  seq_rd_s1;
	logic [TIME_W-1:0] arr_rd_s1;
	logic [COST_W-1:0] cost_rd_s1;
	logic              cmp_en_s1;

	logic [SLOT_W-1:0] walk_q;
	logic [SLOT_W-1:0] who_idx;
	logic [SLOT_W-1:0] rd_addr;
	logic              rd_en;
	logic [TIME_W-1:0] age;
	logic              in_range;
	logic              take;
	logic              beaten;
	logic              acc_q;
	logic              clo_q;

	// Configuration writes; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_player_q <= OWN_PLAYER_RST;
			own_team_q   <= OWN_TEAM_RST;
			gap_q        <= GAP_RST;
			fresh_q      <= FRESH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_OWN_PLAYER:        own_player_q <= cfg_data[PLAYER_W-1:0];
				REG_OWN_TEAM:          own_team_q   <= cfg_data[TEAM_W-1:0];
				REG_ACCEPTANCE_GAP:    gap_q        <= cfg_data[TIME_W-1:0];
				REG_FRESHNESS_TIMEOUT: fresh_q      <= cfg_data[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	// Capture the item word at acceptance.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			who_q  <= sender_player;
			team_q <= sender_team;
			seq_q  <= packet_id;
			cost_q <= time_to_ball;
			now_q  <= current_time;
		end
	end

	// Walk counter over the slots.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q <= '0;
		end else if (cmd.load) begin
			walk_q <= '0;
		end else if (cmd.walk_rd) begin
			walk_q <= walk_q + SLOT_W'(1);
		end
	end

	assign sts.walk_last = (walk_q == SLOT_W'(SLOTS - 1));

	// Read address is the sender's slot for a packet, the walk index for a query.
	assign who_idx = who_q[SLOT_W-1:0];
	assign rd_addr = cmd.pkt_rd ? who_idx : walk_q;
	assign rd_en   = cmd.pkt_rd || cmd.walk_rd;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			seq_rd_s1  <= seq_mem[rd_addr];
			arr_rd_s1  <= arr_mem[rd_addr];
			cost_rd_s1 <= cost_mem[rd_addr];
			vld_rd_s1  <= slot_valid_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_en_s1 <= 1'b0;
		end else begin
			cmp_en_s1 <= cmd.walk_rd;
		end
	end

	// Age of the slot that was read, modulo 2^32.
	assign age = now_q - arr_rd_s1;

	// Packet acceptance decision.
	assign in_range = (who_q != '0)
		&& ({1'b0, who_q} < (PLAYER_W + 1)'(SLOTS))
		&& (who_q != own_player_q)
		&& (team_q == own_team_q);
	assign take = in_range && (!vld_rd_s1 || (age > gap_q) || (seq_q > seq_rd_s1));

	// A fresh teammate with strictly lower cost defeats the query.
	assign beaten = vld_rd_s1 && (age < fresh_q) && (cost_q > cost_rd_s1);

	// Slot store writes.
	always_ff @(posedge clk) begin
		if (cmd.pkt_commit && take) begin
			seq_mem[who_idx]  <= seq_q;
			arr_mem[who_idx]  <= now_q;
			cost_mem[who_idx] <= cost_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
		end else if (cmd.pkt_commit && take) begin
			slot_valid_q[who_idx] <= 1'b1;
		end
	end

	// Result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= 1'b0;
			clo_q <= 1'b0;
		end else if (cmd.load) begin
			acc_q <= 1'b0;
			clo_q <= (op == OP_QUERY);
		end else begin
			if (cmd.pkt_commit) begin
				acc_q <= take;
			end
			if (cmp_en_s1 && beaten) begin
				clo_q <= 1'b0;
			end
		end
	end

	assign accepted = acc_q;
	assign closest  = clo_q;

endmodule
`default_nettype wire

FILE: design/per_sender_sequence_filter_top.sv
// Top level of the per-sender sequence filter.
//
// Usage: a word is taken when start is high and busy is low. op selects a
// received packet or a closest query. A packet is checked against its
// sender's slot and stored if it passes; a query walks every slot and
// reports whether our own cost is no greater than each fresh teammate's.
// Each word yields one result: done is high for exactly one cycle while
// accepted and closest hold the answer. The receiver cannot stall, so the
// result is simply presented for that cycle.
// Busy drops in the cycle done is high, so a new word can start then. A
// packet reads its sender's slot, then decides; a query walk steps through
// the slots over the single slot read port, one slot per cycle.
// Configuration uses its own write channel (cfg_valid, cfg_ready,
// cfg_index, cfg_data); cfg_ready is always high and writes belong to idle
// periods. Reset clears all slot valid marks and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none
module per_sender_sequence_filter_top #(
	parameter int SLOTS = psf_pkg::SLOTS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic                            op,
	input  wire logic [psf_pkg::PLAYER_W-1:0]    sender_player,
	input  wire logic [psf_pkg::TEAM_W-1:0]      sender_team,
	input  wire logic [psf_pkg::SEQ_W-1:0]       packet_id,
	input  wire logic [psf_pkg::COST_W-1:0]      time_to_ball,
	input  wire logic [psf_pkg::TIME_W-1:0]      current_time,
	output logic                                 done,
	output logic                                 accepted,
	output logic                                 closest,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [psf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [psf_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import psf_pkg::*;

	psf_cmd_t cmd;
	psf_sts_t sts;

	assign cfg_ready = 1'b1;

	// Controller.
	psf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// Datapath.
	psf_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.op            (op),
		.sender_player (sender_player),
		.sender_team   (sender_team),
		.packet_id     (packet_id),
		.time_to_ball  (time_to_ball),
		.current_time  (current_time),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.accepted      (accepted),
		.closest       (closest)
	);

endmodule
`default_nettype wire
